### rtl/media_box_structure_parser_core_assert.svh
// Assertion macros for the box parser core.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef MEDIA_BOX_STRUCTURE_PARSER_CORE_ASSERT_SVH
`define MEDIA_BOX_STRUCTURE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MBSP_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("box parser check failed");

// Next-cycle implication.
`define MBSP_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("box parser check failed");

`endif

### rtl/mbsp_pkg.sv
package mbsp_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int MAX_LEVELS  = 3;
	localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int SUM_W       = 65;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	// box type codes, big-endian ASCII
	localparam logic [31:0] T_MOOF = 32'h6d6f6f66;
	localparam logic [31:0] T_MDAT = 32'h6d646174;
	localparam logic [31:0] T_MFHD = 32'h6d666864;
	localparam logic [31:0] T_TRAF = 32'h74726166;
	localparam logic [31:0] T_TFHD = 32'h74666864;
	localparam logic [31:0] T_TRUN = 32'h7472756e;
	localparam logic [31:0] T_UUID = 32'h75756964;

	localparam logic [31:0] MIN_BOX_LEN = 32'd8;
	localparam logic [2:0]  LEN_BYTES   = 3'd4;
	localparam logic [2:0]  HDR_LAST    = 3'd7;

	localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(0);
	localparam logic [LVL_W-1:0] LVL_MOOF = LVL_W'(1);
	localparam logic [LVL_W-1:0] LVL_TRAF = LVL_W'(2);

	localparam logic [1:0] EV_BOX     = 2'd0;
	localparam logic [1:0] EV_NO_MOOF = 2'd1;
	localparam logic [1:0] EV_NO_MDAT = 2'd2;

	localparam logic [2:0] KIND_MOOF = 3'd0;
	localparam logic [2:0] KIND_MDAT = 3'd1;
	localparam logic [2:0] KIND_MFHD = 3'd2;
	localparam logic [2:0] KIND_TRAF = 3'd3;
	localparam logic [2:0] KIND_TFHD = 3'd4;
	localparam logic [2:0] KIND_TRUN = 3'd5;
	localparam logic [2:0] KIND_UUID = 3'd6;

	typedef enum logic [1:0] {
		PH_MOOF,
		PH_INSIDE,
		PH_MDAT,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [2:0]  box_kind;
		logic [31:0] box_length;
		logic [31:0] box_start;
		logic [1:0]  nesting_level;
		logic        last_of_run;
	} result_t;

	// one byte's worth of results: res0 always, res1 when two is set
	typedef struct packed {
		logic    two;
		result_t res0;
		result_t res1;
	} rec_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] kind;
	} child_t;

	function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
		input logic [31:0] b);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b);
		if (sum > SUM_W'(OFF_MAX))
			return OFF_MAX;
		return sum[OFFSET_BITS-1:0];
	endfunction

	function automatic logic [31:0] to_start(input logic [OFFSET_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		if (w > 64'h0000_0000_ffff_ffff)
			return 32'hffff_ffff;
		return w[31:0];
	endfunction

	function automatic child_t child_kind(input logic [LVL_W-1:0] lvl, input logic [31:0] t);
		child_t c;
		c.ok   = 1'b1;
		c.kind = KIND_MOOF;
		if (lvl == LVL_MOOF && t == T_MFHD)
			c.kind = KIND_MFHD;
		else if (lvl == LVL_MOOF && t == T_TRAF)
			c.kind = KIND_TRAF;
		else if (lvl == LVL_TRAF && t == T_TFHD)
			c.kind = KIND_TFHD;
		else if (lvl == LVL_TRAF && t == T_TRUN)
			c.kind = KIND_TRUN;
		else if (lvl == LVL_TRAF && t == T_UUID)
			c.kind = KIND_UUID;
		else
			c.ok = 1'b0;
		return c;
	endfunction

endpackage

### rtl/mbsp_front.sv
module mbsp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          final_byte,
	output logic          push,
	output mbsp_pkg::rec_t rec
);
	import mbsp_pkg::*;

	phase_t                 phase_q, phase_a, phase_h, phase_n;
	logic [2:0]             hbc_q, hbc_a, hbc_n;
	logic [31:0]            len_q, len_g, len_n;
	logic [31:0]            typ_q, typ_g, typ_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] hs_q, hs_g, hs_n;
	logic [OFFSET_BITS-1:0] end_q [MAX_LEVELS];
	logic [OFFSET_BITS-1:0] end_n [MAX_LEVELS];
	logic [OFFSET_BITS-1:0] end_sat, parent_end, child_end;
	logic [LVL_W-1:0]       lvl_q, lvl_a, lvl_n, pidx;
	logic                   skip_q, skip_a, skip_n;
	logic [MAX_LEVELS-1:0]  past_end;
	logic                   popped, gather, hdone, len_ok, moof_ok, mdat_ok, child_ok;
	logic                   hdr_emit, fin_emit;
	child_t                 ck;
	result_t                hdr_res, fin_res;

	// level unwind, header gathering and header decode
	always_comb begin
		for (int i = 0; i < MAX_LEVELS; i++)
			past_end[i] = pos_q >= end_q[i];
		lvl_a   = lvl_q;
		popped  = 1'b0;
		phase_a = phase_q;
		skip_a  = skip_q;
		hbc_a   = hbc_q;
		if (phase_q == PH_INSIDE) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				if (lvl_a != LVL_TOP && past_end[lvl_a - LVL_W'(1)]) begin
					lvl_a  = lvl_a - LVL_W'(1);
					popped = 1'b1;
				end
			end
			if (popped) begin
				skip_a = 1'b0;
				hbc_a  = '0;
			end
			if (lvl_a == LVL_TOP) begin
				phase_a = PH_MDAT;
				hbc_a   = '0;
			end
		end

		gather = (phase_a != PH_DONE) && !(phase_a == PH_INSIDE && skip_a);
		hs_g   = (hbc_a == '0) ? pos_q : hs_q;
		if (hbc_a < LEN_BYTES) begin
			len_g = {len_q[23:0], data_byte};
			typ_g = typ_q;
		end else begin
			len_g = len_q;
			typ_g = {typ_q[23:0], data_byte};
		end
		hdone    = gather && (hbc_a == HDR_LAST);
		len_ok   = len_g >= MIN_BOX_LEN;
		ck       = child_kind(lvl_a, typ_g);
		moof_ok  = (typ_g == T_MOOF) && len_ok;
		mdat_ok  = (typ_g == T_MDAT) && len_ok;
		child_ok = len_ok && ck.ok;

		end_sat    = sat_add(hs_g, len_g);
		pidx       = (lvl_a == LVL_TOP) ? LVL_TOP : lvl_a - LVL_W'(1);
		parent_end = end_q[pidx];
		child_end  = (end_sat > parent_end) ? parent_end : end_sat;

		phase_h  = phase_a;
		hdr_emit = 1'b0;
		if (hdone) begin
			unique case (phase_a)
				PH_MOOF: begin
					hdr_emit = 1'b1;
					phase_h  = moof_ok ? PH_INSIDE : PH_DONE;
				end
				PH_MDAT: begin
					hdr_emit = 1'b1;
					phase_h  = PH_DONE;
				end
				PH_INSIDE: hdr_emit = child_ok;
				PH_DONE:   hdr_emit = 1'b0;
			endcase
		end
		fin_emit = final_byte && (phase_h != PH_DONE);
	end

	// next state
	always_comb begin
		phase_n = phase_h;
		hbc_n   = hbc_a;
		len_n   = len_q;
		typ_n   = typ_q;
		hs_n    = hs_q;
		lvl_n   = lvl_a;
		skip_n  = skip_a;
		end_n   = end_q;
		pos_n   = (pos_q == OFF_MAX) ? pos_q : pos_q + OFFSET_BITS'(1);
		if (gather) begin
			hbc_n = hdone ? 3'd0 : hbc_a + 3'd1;
			len_n = len_g;
			typ_n = typ_g;
			hs_n  = hs_g;
		end
		if (hdone && phase_a == PH_MOOF && moof_ok) begin
			end_n[0] = end_sat;
			lvl_n    = LVL_MOOF;
			skip_n   = 1'b0;
		end
		if (hdone && phase_a == PH_INSIDE) begin
			if (child_ok) begin
				end_n[lvl_a] = child_end;
				lvl_n        = lvl_a + LVL_W'(1);
				skip_n       = ck.kind != KIND_TRAF;
			end else begin
				skip_n = 1'b1;
			end
		end
		// last byte of the file: back to the reset state
		if (final_byte) begin
			phase_n = PH_MOOF;
			hbc_n   = '0;
			len_n   = '0;
			typ_n   = '0;
			hs_n    = '0;
			pos_n   = '0;
			lvl_n   = LVL_TOP;
			skip_n  = 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++)
				end_n[i] = '0;
		end
	end

	// results for this byte
	always_comb begin
		hdr_res.event_kind    = EV_BOX;
		hdr_res.box_kind      = ck.kind;
		hdr_res.box_length    = len_g;
		hdr_res.box_start     = to_start(hs_g);
		hdr_res.nesting_level = lvl_a;
		hdr_res.last_of_run   = !fin_emit;
		unique case (phase_a)
			PH_MOOF: begin
				hdr_res.box_kind      = KIND_MOOF;
				hdr_res.nesting_level = LVL_TOP;
				if (!moof_ok) begin
					hdr_res.event_kind = EV_NO_MOOF;
					hdr_res.box_length = '0;
					hdr_res.box_start  = '0;
				end
			end
			PH_MDAT: begin
				hdr_res.box_kind      = KIND_MDAT;
				hdr_res.nesting_level = LVL_TOP;
				if (!mdat_ok) begin
					hdr_res.event_kind = EV_NO_MDAT;
					hdr_res.box_kind   = KIND_MOOF;
					hdr_res.box_length = '0;
					hdr_res.box_start  = '0;
				end
			end
			PH_INSIDE: hdr_res.event_kind = EV_BOX;
			PH_DONE:   hdr_res.event_kind = EV_BOX;
		endcase

		fin_res.event_kind    = (phase_h == PH_MOOF) ? EV_NO_MOOF : EV_NO_MDAT;
		fin_res.box_kind      = KIND_MOOF;
		fin_res.box_length    = '0;
		fin_res.box_start     = '0;
		fin_res.nesting_level = LVL_TOP;
		fin_res.last_of_run   = 1'b1;

		push     = accept && (hdr_emit || fin_emit);
		rec.two  = hdr_emit && fin_emit;
		rec.res0 = hdr_emit ? hdr_res : fin_res;
		rec.res1 = fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MOOF;
			hbc_q   <= '0;
			len_q   <= '0;
			typ_q   <= '0;
			hs_q    <= '0;
			pos_q   <= '0;
			lvl_q   <= LVL_TOP;
			skip_q  <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++)
				end_q[i] <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			hbc_q   <= hbc_n;
			len_q   <= len_n;
			typ_q   <= typ_n;
			hs_q    <= hs_n;
			pos_q   <= pos_n;
			lvl_q   <= lvl_n;
			skip_q  <= skip_n;
			end_q   <= end_n;
		end
	end

endmodule

### rtl/mbsp_queue.sv
module mbsp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mbsp_pkg::rec_t     rec_in,
	input  logic               pop,
	output mbsp_pkg::rec_t     head,
	output mbsp_pkg::q_status_t status
);
	import mbsp_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= rec_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head             = mem_q[rd_q];
	assign status.not_empty = cnt_q != '0;
	assign status.full      = cnt_q == QCNT_W'(QDEPTH);

endmodule

### rtl/mbsp_back.sv
module mbsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mbsp_pkg::rec_t head,
	input  logic           head_valid,
	output logic           pop,
	output logic           event_valid,
	input  logic           event_stall,
	output logic [1:0]     event_kind,
	output logic [2:0]     box_kind,
	output logic [31:0]    box_length,
	output logic [31:0]    box_start,
	output logic [1:0]     nesting_level,
	output logic           last_of_run
);
	import mbsp_pkg::*;

	result_t out_q, pend_q;
	logic    out_valid_q, pend_valid_q, load;

	// output slot free or emptied this cycle
	assign load = !out_valid_q || !event_stall;
	assign pop  = load && !pend_valid_q && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (head_valid) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= head.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (head_valid) begin
				out_q  <= head.res0;
				pend_q <= head.res1;
			end
		end
	end

	assign event_valid   = out_valid_q;
	assign event_kind    = out_q.event_kind;
	assign box_kind      = out_q.box_kind;
	assign box_length    = out_q.box_length;
	assign box_start     = out_q.box_start;
	assign nesting_level = out_q.nesting_level;
	assign last_of_run   = out_q.last_of_run;

endmodule

### rtl/media_box_structure_parser_core.sv
// Fragment box parser: walks moof / traf headers of a media file fed one byte per item.
// Byte channel: byte_valid, byte_stall, data_byte, final_byte. An item is taken at a
//   clock edge with byte_valid high and byte_stall low; final_byte marks the file's end.
// Event channel: event_valid, event_stall and the result fields. Each byte gives zero,
//   one or two events; last_of_run flags the last event of a byte.
// Throughput: one byte per cycle while the queue is not full. Header assembly, level
//   unwind and header decode all sit in the front stage.
// Each event passes the queue, written at the edge that takes its byte, and then the
//   output register, loaded once the output slot is free; events may wait in between.
// A four-entry queue of per-byte event records separates front and back. The back end
//   drains one event per cycle unless stalled; a two-event byte delays the next record.
// byte_stall rises only when that queue is full, i.e. when the receiver has held
//   event_stall long enough to back it up; nothing is lost or reordered.
// Reset clears the parser to "expecting moof" at offset zero and empties the queue.
// After the final byte the parser is back in that state and the next byte starts
//   a new file.
`include "media_box_structure_parser_core_assert.svh"

module media_box_structure_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [1:0]  event_kind,
	output logic [2:0]  box_kind,
	output logic [31:0] box_length,
	output logic [31:0] box_start,
	output logic [1:0]  nesting_level,
	output logic        last_of_run
);
	import mbsp_pkg::*;

	logic      accept;
	logic      q_push;
	logic      q_pop;
	rec_t      q_in;
	rec_t      q_head;
	q_status_t q_status;
	logic      head_last_ok;

	// stall comes from registered queue occupancy only
	assign byte_stall = q_status.full;
	assign accept     = byte_valid && !byte_stall;

	// front: per-byte parse state, emits a record of events for the byte
	mbsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.push       (q_push),
		.rec        (q_in)
	);

	mbsp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.rec_in (q_in),
		.pop    (q_pop),
		.head   (q_head),
		.status (q_status)
	);

	// back: splits records into single events behind the output register
	mbsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.head_valid    (q_status.not_empty),
		.pop           (q_pop),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_kind    (event_kind),
		.box_kind      (box_kind),
		.box_length    (box_length),
		.box_start     (box_start),
		.nesting_level (nesting_level),
		.last_of_run   (last_of_run)
	);

	// a queued record flags exactly its final event
	assign head_last_ok = q_head.two ?
		(q_head.res1.last_of_run && !q_head.res0.last_of_run) : q_head.res0.last_of_run;

	// a record is only written when there is room for it
	`MBSP_ASSERT_NOW(a_no_overflow, q_push, !q_status.full)
	`MBSP_ASSERT_NOW(a_head_last, q_status.not_empty, head_last_ok)
	// the second event of a byte follows its first without a gap
	`MBSP_ASSERT_NEXT(a_pair_follows, event_valid && !event_stall && !last_of_run, event_valid)

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mbsp_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTS   = 50;

	// Shadow of the parser: tracks header assembly, the level stack and the
	// phase of the current file, and queues the events each byte should cause.
	class box_event_scoreboard;
		phase_t      phase;
		int unsigned hdr_count;
		logic [31:0] len_acc;
		logic [31:0] type_acc;
		logic [63:0] position;
		int          level;
		logic [63:0] level_end [MAX_LEVELS];
		bit          skipping;
		logic [63:0] hdr_start;

		result_t     byte_events [$];
		result_t     expected_events [$];
		int          errors;
		int          events_seen [3];

		function new();
			errors = 0;
			foreach (events_seen[i])
				events_seen[i] = 0;
			restart_file();
		endfunction

		function void restart_file();
			phase     = PH_MOOF;
			hdr_count = 0;
			len_acc   = '0;
			type_acc  = '0;
			position  = '0;
			level     = 0;
			foreach (level_end[i])
				level_end[i] = '0;
			skipping  = 1'b0;
			hdr_start = '0;
		endfunction

		function logic [63:0] off_sum(logic [63:0] a, logic [63:0] b);
			logic [63:0] top;
			top = {64{1'b1}} >> (64 - OFFSET_BITS);
			if (a > top)
				a = top;
			if (b > top - a)
				return top;
			return a + b;
		endfunction

		function bit child_of(int lvl, logic [31:0] t, output logic [2:0] kind);
			kind = KIND_MOOF;
			if (lvl == LVL_MOOF) begin
				if (t == T_MFHD) begin kind = KIND_MFHD; return 1'b1; end
				if (t == T_TRAF) begin kind = KIND_TRAF; return 1'b1; end
			end else if (lvl == LVL_TRAF) begin
				if (t == T_TFHD) begin kind = KIND_TFHD; return 1'b1; end
				if (t == T_TRUN) begin kind = KIND_TRUN; return 1'b1; end
				if (t == T_UUID) begin kind = KIND_UUID; return 1'b1; end
			end
			return 1'b0;
		endfunction

		function void add_event(logic [1:0] ev, logic [2:0] kind, logic [31:0] len,
			logic [63:0] start, int lvl);
			result_t r;
			if (byte_events.size() >= 2)
				return;
			r.event_kind    = ev;
			r.box_kind      = kind;
			r.box_length    = len;
			r.box_start     = (start > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : start[31:0];
			r.nesting_level = 2'(lvl);
			r.last_of_run   = 1'b0;
			byte_events.push_back(r);
		endfunction

		function void header_complete();
			logic [2:0]  kind;
			bit          known;
			logic [63:0] box_end;
			case (phase)
				PH_MOOF: begin
					if (type_acc == T_MOOF && len_acc >= MIN_BOX_LEN) begin
						add_event(EV_BOX, KIND_MOOF, len_acc, hdr_start, LVL_TOP);
						level_end[0] = off_sum(hdr_start, len_acc);
						level        = 1;
						skipping     = 1'b0;
						phase        = PH_INSIDE;
					end else begin
						add_event(EV_NO_MOOF, KIND_MOOF, '0, '0, LVL_TOP);
						phase = PH_DONE;
					end
				end
				PH_MDAT: begin
					if (type_acc == T_MDAT && len_acc >= MIN_BOX_LEN)
						add_event(EV_BOX, KIND_MDAT, len_acc, hdr_start, LVL_TOP);
					else
						add_event(EV_NO_MDAT, KIND_MOOF, '0, '0, LVL_TOP);
					phase = PH_DONE;
				end
				PH_INSIDE: begin
					known = child_of(level, type_acc, kind);
					if (len_acc < MIN_BOX_LEN || !known || level < 1 || level >= MAX_LEVELS) begin
						// rest of the parent is skipped, nothing reported
						skipping = 1'b1;
					end else begin
						add_event(EV_BOX, kind, len_acc, hdr_start, level);
						box_end = off_sum(hdr_start, len_acc);
						if (box_end > level_end[level-1])
							box_end = level_end[level-1];
						level_end[level] = box_end;
						level            = level + 1;
						skipping         = (kind != KIND_TRAF);
					end
				end
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] data, logic fin);
			logic [63:0] here;
			here = position;
			byte_events.delete();

			if (phase == PH_INSIDE) begin
				while (level > 0 && level <= MAX_LEVELS && here >= level_end[level-1]) begin
					level     = level - 1;
					skipping  = 1'b0;
					hdr_count = 0;
				end
				if (level == 0 || level > MAX_LEVELS) begin
					level     = 0;
					phase     = PH_MDAT;
					hdr_count = 0;
				end
			end

			if (phase != PH_DONE && !(phase == PH_INSIDE && skipping)) begin
				if (hdr_count == 0)
					hdr_start = here;
				if (hdr_count < LEN_BYTES)
					len_acc = {len_acc[23:0], data};
				else
					type_acc = {type_acc[23:0], data};
				if (hdr_count == HDR_LAST) begin
					hdr_count = 0;
					header_complete();
				end else begin
					hdr_count = hdr_count + 1;
				end
			end

			position = off_sum(here, 1);

			if (fin) begin
				if (phase == PH_MOOF)
					add_event(EV_NO_MOOF, KIND_MOOF, '0, '0, LVL_TOP);
				else if (phase == PH_INSIDE || phase == PH_MDAT)
					add_event(EV_NO_MDAT, KIND_MOOF, '0, '0, LVL_TOP);
				restart_file();
			end

			if (byte_events.size() > 0)
				byte_events[byte_events.size()-1].last_of_run = 1'b1;
			foreach (byte_events[i])
				expected_events.push_back(byte_events[i]);
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		task report_mismatch(string what);
			if (errors < MAX_PRINTS)
				$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_event(result_t got);
			result_t want;
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind %0d box %0d start %0h",
					got.event_kind, got.box_kind, got.box_start));
				return;
			end
			want = expected_events.pop_front();
			if (got.event_kind < 3)
				events_seen[got.event_kind]++;
			if (got.event_kind != want.event_kind)
				report_mismatch($sformatf("event_kind %0d, want %0d",
					got.event_kind, want.event_kind));
			if (got.box_kind != want.box_kind)
				report_mismatch($sformatf("box_kind %0d, want %0d", got.box_kind, want.box_kind));
			if (got.box_length != want.box_length)
				report_mismatch($sformatf("box_length %0h, want %0h",
					got.box_length, want.box_length));
			if (got.box_start != want.box_start)
				report_mismatch($sformatf("box_start %0h, want %0h",
					got.box_start, want.box_start));
			if (got.nesting_level != want.nesting_level)
				report_mismatch($sformatf("nesting_level %0d, want %0d",
					got.nesting_level, want.nesting_level));
			if (got.last_of_run != want.last_of_run)
				report_mismatch($sformatf("last_of_run %0d, want %0d",
					got.last_of_run, want.last_of_run));
		endtask
	endclass

	// clock and block ports; all that the bench drives is known from time zero
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        byte_valid  = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte   = 8'h00;
	logic        final_byte  = 1'b0;
	logic        event_valid;
	logic        event_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [2:0]  box_kind;
	logic [31:0] box_length;
	logic [31:0] box_start;
	logic [1:0]  nesting_level;
	logic        last_of_run;

	box_event_scoreboard sb = new();

	logic [7:0]  file_bytes [$];   // file being built, sent byte by byte
	int unsigned ignored_tail;     // mdat body bytes the parser will not look at
	int          files_sent   = 0;
	int          bytes_sent   = 0;
	int          cycle_count  = 0;
	int          stall_left   = 0;
	bit          quiet        = 1'b0;   // no gaps and no stalls while set
	result_t     seen;

	always #2 clk = ~clk;

	media_box_structure_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.event_valid   (event_valid),
		.event_stall   (event_stall),
		.event_kind    (event_kind),
		.box_kind      (box_kind),
		.box_length    (box_length),
		.box_start     (box_start),
		.nesting_level (nesting_level),
		.last_of_run   (last_of_run)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Both handshakes are sampled here, in one process: the byte is noted
	// before any event is compared, so ordering within the edge cannot matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				sb.note_byte(data_byte, final_byte);
			if (event_valid && !event_stall) begin
				seen.event_kind    = event_kind;
				seen.box_kind      = box_kind;
				seen.box_length    = box_length;
				seen.box_start     = box_start;
				seen.nesting_level = nesting_level;
				seen.last_of_run   = last_of_run;
				sb.check_event(seen);
			end
		end
	end

	// Receiver back-pressure: runs of stall / no stall of random length.
	always @(negedge clk) begin
		if (!arst_n || quiet) begin
			event_stall <= 1'b0;
			stall_left  <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			event_stall <= ($urandom_range(0, 2) == 0);
			stall_left  <= pick_gap();
		end
	end

	// Watchdog: a hung handshake or a lost event ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run timed out after %0d cycles, %0d events still due",
			cycle_count, sb.pending());
		$display("FAILURE");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	// valid is only lowered ahead of a gap, so it never drops and rises in one step.
	task automatic send_byte(logic [7:0] value, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= value;
		final_byte <= last;
		do
			@(posedge clk);
		while (byte_stall);
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		files_sent++;
		bytes_sent += file_bytes.size();
	endtask

	// Hold the byte channel until the event channel has caught up.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic push_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			file_bytes.push_back(w[8*i +: 8]);
	endtask

	task automatic push_body(int unsigned n);
		repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// big-endian length backfilled once the box contents are known
	task automatic patch_len(int unsigned at, logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes[at+i] = w[8*(3-i) +: 8];
	endtask

	// Mostly the true length; sometimes short (header cut by parent end),
	// long (overrun of the parent) or anything at all.
	function automatic logic [31:0] fuzz_len(logic [31:0] good);
		case ($urandom_range(0, 19))
			0:       return good - $urandom_range(1, 6);
			1:       return good + $urandom_range(1, 12);
			2:       return $urandom();
			default: return good;
		endcase
	endfunction

	// a child the parser must refuse: too short, or of a type its parent does not hold
	task automatic push_bad_child(logic [31:0] misplaced);
		logic [31:0] kind_code;
		int unsigned body;
		case ($urandom_range(0, 2))
			0:       kind_code = $urandom();
			1:       kind_code = T_MOOF;
			default: kind_code = misplaced;
		endcase
		body = $urandom_range(0, 10);
		if ($urandom_range(0, 1))
			push_word($urandom_range(0, 7));
		else
			push_word(8 + body);
		push_word(kind_code);
		push_body(body);
	endtask

	task automatic push_traf_child();
		int unsigned at;
		int unsigned pick;
		at = file_bytes.size();
		pick = $urandom_range(0, 9);
		if (pick < 9) begin
			push_word(0);
			push_word(pick < 3 ? T_TFHD : (pick < 6 ? T_TRUN : T_UUID));
			push_body($urandom_range(0, 5));
			patch_len(at, fuzz_len(file_bytes.size() - at));
		end else begin
			push_bad_child(T_MFHD);
		end
	endtask

	task automatic push_moof_child();
		int unsigned at;
		int unsigned pick;
		at = file_bytes.size();
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			push_word(0);
			push_word(T_MFHD);
			push_body($urandom_range(0, 6));
			patch_len(at, fuzz_len(file_bytes.size() - at));
		end else if (pick < 8) begin
			push_word(0);
			push_word(T_TRAF);
			repeat ($urandom_range(0, 3)) push_traf_child();
			patch_len(at, fuzz_len(file_bytes.size() - at));
		end else begin
			push_bad_child(T_TFHD);
		end
	endtask

	// One file: mostly moof / children / mdat with random content, plus some
	// plain noise, wrong top-level boxes and files cut short.
	task automatic build_file();
		int unsigned style;
		int unsigned cut;
		int unsigned body;
		file_bytes.delete();
		ignored_tail = 0;
		style = $urandom_range(0, 11);
		if (style == 0) begin
			push_body($urandom_range(1, 20));
		end else begin
			push_word(0);
			push_word(style == 1 ? $urandom() : T_MOOF);
			repeat ($urandom_range(0, 3)) push_moof_child();
			patch_len(0, fuzz_len(file_bytes.size()));
			push_word(style == 2 ? $urandom_range(0, 7) : $urandom_range(8, 4000));
			push_word(style == 3 ? $urandom() : T_MDAT);
			body = $urandom_range(0, 4);
			push_body(body);
			ignored_tail = body;
		end
		if ($urandom_range(0, 5) == 0 && file_bytes.size() > 1) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
			ignored_tail = 0;
		end
	endtask

	initial begin
		int useful_bytes;
		useful_bytes = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// final byte before any header: moof missing on early end
		file_bytes = '{8'hff};
		send_file();

		// smallest moof, then mdat with the largest length; the byte after
		// the verdict is ignored
		file_bytes.delete();
		push_word(MIN_BOX_LEN);
		push_word(T_MOOF);
		push_word(32'hffff_ffff);
		push_word(T_MDAT);
		file_bytes.push_back(8'h00);
		send_file();

		// top-level moof whose length is below the header size
		file_bytes.delete();
		push_word(MIN_BOX_LEN - 1);
		push_word(T_MOOF);
		send_file();

		// random files; every few files the sender waits for all events,
		// and some files run with no gaps or stalls at all
		while (useful_bytes < RANDOM_ITEMS) begin
			quiet = (files_sent % 5 == 0);
			build_file();
			send_file();
			useful_bytes += file_bytes.size() - ignored_tail;
			if (files_sent % 7 == 3)
				wait_drained();
		end
		quiet = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d files, %0d bytes; checked %0d found boxes, %0d moof-missing",
			files_sent, bytes_sent, sb.events_seen[EV_BOX], sb.events_seen[EV_NO_MOOF]);
		$display("and %0d mdat-missing events; %0d mismatches in %0d cycles",
			sb.events_seen[EV_NO_MDAT], sb.errors, cycle_count);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/mbsp_pkg.sv
rtl/mbsp_front.sv
rtl/mbsp_queue.sv
rtl/mbsp_back.sv
rtl/media_box_structure_parser_core.sv
dv/testbench.sv
